@@ rtl/trial_division_prime_test_defines.svh @@
// Assertion macros for the prime test block
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TDPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tdpt_pkg.sv @@
`timescale 1ns / 1ps

package tdpt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a candidate
    ST_REM,    // bit-serial remainder, one candidate bit per cycle
    ST_EVAL,   // look at the remainder
    ST_BOUND,  // divisor squared against candidate
    ST_DONE    // hand result to the output register
  } tdpt_state_t;

  localparam int DIV_SIX   = 6;
  localparam int FIRST_DIV = 5;
  localparam int FIRST_SQ  = 25;
  localparam int DIV_STEP  = 2;
  localparam int RES_ONE   = 1;
  localparam int RES_FIVE  = 5;
  localparam int SMALL_P0  = 2;
  localparam int SMALL_P1  = 3;

endpackage

@@ rtl/trial_division_prime_test.sv @@
`timescale 1ns / 1ps

// Trial-division primality test. One WIDTH-bit unsigned candidate goes in per
// input beat and one result beat comes out: is_prime is 1 for a prime, 0 for
// zero, one and every composite. The candidate is first reduced modulo 6; 2 and
// 3 are prime, anything not 1 or 5 modulo 6 is composite. Otherwise odd
// divisors from 5 upward are tried while the divisor squared does not exceed
// the candidate. Every remainder, including the modulo-6 one, is formed by a
// single bit-serial restoring unit that shifts the candidate in MSB first, one
// bit per cycle, so each divisor costs WIDTH shift steps, one evaluate step
// and one bound check. Composites finish at their smallest factor. The block
// works on one candidate at a time but takes the next one while the previous
// result still waits in the output register.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [((WIDTH + 7) / 8) * 8-1:0] in_tdata,  // [WIDTH-1:0] candidate
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata   // [0] is_prime
);

`include "trial_division_prime_test_defines.svh"

  localparam int DW  = WIDTH / 2 + 3;       // divisor and remainder width
  localparam int SQW = WIDTH + 3;           // running divisor squared
  localparam int CW  = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  tdpt_state_t state_r, state_nxt;

  logic [WIDTH-1:0] n_r, n_nxt;             // candidate, held
  logic [WIDTH-1:0] sh_r, sh_nxt;           // candidate bits still to shift in
  logic [DW-1:0]    d_r, d_nxt;             // current divisor
  logic [DW-1:0]    r_r, r_nxt;             // partial remainder, < d_r in ST_REM and ST_EVAL
  logic [SQW-1:0]   sq_r, sq_nxt;           // d_r squared
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             first_r, first_nxt;     // modulo-6 pass
  logic             res_r, res_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             prime_r, prime_nxt;

  logic             in_beat;
  logic             out_free;
  logic [DW:0]      r_shift;
  logic             r_ge;
  logic             sq_over;

  assign in_beat  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // one restoring step: shift in the next candidate bit, subtract if it fits
  assign r_shift = {r_r, sh_r[WIDTH-1]};
  assign r_ge    = (r_shift >= {1'b0, d_r});
  assign sq_over = (sq_r > {3'b000, n_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = ST_REM;
      end
      ST_REM: begin
        if (cnt_r == CW'(WIDTH - 1)) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (first_r) begin
          if ((n_r == WIDTH'(SMALL_P0)) || (n_r == WIDTH'(SMALL_P1)) ||
              (n_r < WIDTH'(SMALL_P0)) ||
              ((r_r != DW'(RES_ONE)) && (r_r != DW'(RES_FIVE)))) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_BOUND;
          end
        end else if (r_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: begin
        state_nxt = sq_over ? ST_DONE : ST_REM;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    n_nxt     = n_r;
    sh_nxt    = sh_r;
    d_nxt     = d_r;
    r_nxt     = r_r;
    sq_nxt    = sq_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          n_nxt     = in_tdata[WIDTH-1:0];
          sh_nxt    = in_tdata[WIDTH-1:0];
          d_nxt     = DW'(DIV_SIX);
          r_nxt     = '0;
          cnt_nxt   = '0;
          first_nxt = 1'b1;
        end
      end
      ST_REM: begin
        r_nxt   = r_ge ? DW'(r_shift - {1'b0, d_r}) : r_shift[DW-1:0];
        sh_nxt  = {sh_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
      end
      ST_EVAL: begin
        if (first_r) begin
          if ((n_r == WIDTH'(SMALL_P0)) || (n_r == WIDTH'(SMALL_P1))) begin
            res_nxt = 1'b1;
          end else if ((n_r < WIDTH'(SMALL_P0)) ||
                       ((r_r != DW'(RES_ONE)) && (r_r != DW'(RES_FIVE)))) begin
            res_nxt = 1'b0;
          end else begin
            d_nxt     = DW'(FIRST_DIV);
            sq_nxt    = SQW'(FIRST_SQ);
            first_nxt = 1'b0;
          end
        end else if (r_r == '0) begin
          res_nxt = 1'b0;
        end else begin
          // (d + 2)^2 = d^2 + 4d + 4
          d_nxt  = d_r + DW'(DIV_STEP);
          sq_nxt = sq_r + SQW'({d_r, 2'b00}) + SQW'(4);
        end
      end
      ST_BOUND: begin
        if (sq_over) begin
          res_nxt = 1'b1;
        end else begin
          sh_nxt  = n_r;
          r_nxt   = '0;
          cnt_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    prime_nxt      = prime_r;
    if ((state_r == ST_DONE) && out_free) begin
      out_tvalid_nxt = 1'b1;
      prime_nxt      = res_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0000000, prime_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      first_r      <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      first_r      <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    sh_r    <= sh_nxt;
    d_r     <= d_nxt;
    r_r     <= r_nxt;
    sq_r    <= sq_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
    prime_r <= prime_nxt;
  end

  // checks
  `TDPT_ASSERT_NOW(a_rem_below_div, (state_r == ST_REM) || (state_r == ST_EVAL), r_r < d_r, "partial remainder not below divisor")
  `TDPT_ASSERT_NOW(a_trial_div_odd, !first_r && (state_r == ST_REM), d_r[0] && (d_r >= DW'(FIRST_DIV)), "trial divisor even or below five")
  `TDPT_ASSERT_NEXT(a_start_clean, in_beat, (state_r == ST_REM) && (cnt_r == '0) && first_r, "candidate beat did not start the modulo-six pass")

endmodule
